FILE: hdl/srep_pkg.sv
// shared types and constants for the stream string replace unit
// no dependencies; used by every module under hdl

package srep_pkg;

   // result slots: a replacement or a flush of the window plus one byte
   localparam int BURST_DEPTH = 8;
   // wide enough to count 0..BURST_DEPTH
   localparam int CNT_W       = 4;
   localparam int REG_W       = 64;
   localparam int LEN_W       = 4;

   typedef enum logic [1:0] {
      REG_PATTERN_BYTES  = 2'd0,
      REG_PATTERN_LENGTH = 2'd1,
      REG_REPLACE_BYTES  = 2'd2,
      REG_REPLACE_LENGTH = 2'd3
   } csr_index_type;

   // one output slot of the result chain
   typedef struct packed {
      logic       valid;
      logic       last;
      logic [7:0] data;
   } slot_type;

   // per-cell select for the window chain
   typedef struct packed {
      logic take_nbr;
      logic take_new;
   } win_ctrl_type;

endpackage

FILE: hdl/srep_win_cell.sv
// one window cell: holds a byte, takes its neighbor or the new byte,
// compares against its pattern byte; depends on srep_pkg

module srep_win_cell (
   input  logic                    clock,
   input  srep_pkg::win_ctrl_type  ctrl,
   input  logic [7:0]              nbr_byte,
   input  logic [7:0]              new_byte,
   input  logic [7:0]              pat_byte,
   output logic [7:0]              held_byte,
   output logic                    hit
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (ctrl.take_nbr) begin
         byte_in = nbr_byte;
      end else if (ctrl.take_new) begin
         byte_in = new_byte;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign held_byte = byte_ff;
   assign hit       = (byte_ff == pat_byte);

endmodule

FILE: hdl/srep_out_cell.sv
// one result slot: loads from the burst builder or takes the slot above
// as words drain; depends on srep_pkg

module srep_out_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                advance,
   input  srep_pkg::slot_type  load_slot,
   input  srep_pkg::slot_type  next_slot,
   output srep_pkg::slot_type  slot
);

   logic       valid_ff;
   logic       valid_in;
   logic       last_ff;
   logic       last_in;
   logic [7:0] data_ff;
   logic [7:0] data_in;

   always_comb begin
      valid_in = valid_ff;
      last_in  = last_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = load_slot.valid;
         last_in  = load_slot.last;
         data_in  = load_slot.data;
      end else if (advance) begin
         valid_in = next_slot.valid;
         last_in  = next_slot.last;
         data_in  = next_slot.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      last_ff <= last_in;
      data_ff <= data_in;
   end

   assign slot.valid = valid_ff;
   assign slot.last  = last_ff;
   assign slot.data  = data_ff;

endmodule

FILE: hdl/stream_string_replace_unit.sv
// stream string replace unit: first result word in the cycle after the input
// word is taken; one byte per cycle while rsp_tready is high; an input causing
// n > 1 result words holds the input side while the result slot chain drains.
// synchronous active-high reset empties the window and the result slots and
// restores the registers (pattern length 1, replace length 0, strings zero).
// uses srep_pkg, srep_win_cell, srep_out_cell

module stream_string_replace_unit #(
   parameter int PATTERN_MAX = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   // req_tdata: [7:0] data_byte
   input  logic [7:0]                req_tdata,
   input  logic                      req_tlast,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // rsp_tdata: [7:0] out_byte
   output logic [7:0]                rsp_tdata,
   output logic                      rsp_tlast,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic                      csr_we,
   input  logic [1:0]                csr_addr,
   input  logic [srep_pkg::REG_W-1:0] csr_wdata
);

   localparam int WIN_DEPTH = (PATTERN_MAX > 1) ? PATTERN_MAX - 1 : 1;
   localparam int FILL_W    = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int CNT_W     = srep_pkg::CNT_W;
   localparam int LEN_W     = srep_pkg::LEN_W;
   localparam int DEPTH     = srep_pkg::BURST_DEPTH;

   logic [srep_pkg::REG_W-1:0] pattern_ff;
   logic [srep_pkg::REG_W-1:0] replace_ff;
   logic [LEN_W-1:0]           plen_ff;
   logic [LEN_W-1:0]           rlen_ff;
   logic [FILL_W-1:0]          fill_ff;
   logic [FILL_W-1:0]          fill_in;

   logic [LEN_W-1:0]  plen_eff;
   logic [LEN_W-1:0]  need_full;
   logic [FILL_W-1:0] need;
   logic [CNT_W-1:0]  rlen_eff;
   logic [FILL_W-1:0] fill_eff;
   logic [CNT_W-1:0]  fill_cnt;

   logic              accept;
   logic              advance;
   logic              win_full;
   logic              match;
   logic              shift_en;
   logic [7:0]        pat_last;
   logic [CNT_W-1:0]  burst_cnt;

   logic [7:0]              win_byte [WIN_DEPTH];
   logic [7:0]              win_pad  [DEPTH];
   logic [WIN_DEPTH-1:0]    win_hit;
   logic [WIN_DEPTH-1:0]    win_active;
   srep_pkg::win_ctrl_type  win_ctrl [WIN_DEPTH];

   srep_pkg::slot_type load_slot [DEPTH];
   srep_pkg::slot_type slot      [DEPTH];
   srep_pkg::slot_type next_slot [DEPTH];

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         plen_ff    <= LEN_W'(1);
         replace_ff <= '0;
         rlen_ff    <= '0;
      end else if (csr_we) begin
         case (srep_pkg::csr_index_type'(csr_addr))
            srep_pkg::REG_PATTERN_BYTES:  pattern_ff <= csr_wdata;
            srep_pkg::REG_PATTERN_LENGTH: plen_ff    <= csr_wdata[LEN_W-1:0];
            srep_pkg::REG_REPLACE_BYTES:  replace_ff <= csr_wdata;
            srep_pkg::REG_REPLACE_LENGTH: rlen_ff    <= csr_wdata[LEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      plen_eff = plen_ff;
      if (plen_ff == '0) begin
         plen_eff = LEN_W'(1);
      end else if (plen_ff > LEN_W'(PATTERN_MAX)) begin
         plen_eff = LEN_W'(PATTERN_MAX);
      end
      need_full = plen_eff - LEN_W'(1);
      need      = need_full[FILL_W-1:0];
      rlen_eff  = (rlen_ff > CNT_W'(DEPTH)) ? CNT_W'(DEPTH) : CNT_W'(rlen_ff);
      fill_eff  = (fill_ff > need) ? need : fill_ff;
      fill_cnt  = CNT_W'(fill_eff);
   end

   // ---------------- window cell chain ----------------
   assign accept  = req_tvalid && req_tready;
   assign advance = rsp_tvalid && rsp_tready;

   always_comb begin
      pat_last = pattern_ff[7:0];
      for (int k = 0; k < PATTERN_MAX; k++) begin
         if (FILL_W'(k) == need) begin
            pat_last = pattern_ff[8*k +: 8];
         end
      end
   end

   assign win_full = (fill_eff == need);
   assign match    = win_full && (req_tdata == pat_last) && (&(win_hit | ~win_active));
   assign shift_en = accept && win_full && !match && (need != '0);

   for (genvar k = 0; k < WIN_DEPTH; k++) begin : g_win
      logic [7:0] nbr;
      if (k + 1 < WIN_DEPTH) begin : g_mid
         assign nbr = win_byte[k+1];
      end else begin : g_end
         assign nbr = 8'h00;
      end

      assign win_active[k]        = (FILL_W'(k) < need);
      assign win_ctrl[k].take_nbr = shift_en && (FILL_W'(k + 1) < need);
      assign win_ctrl[k].take_new = (shift_en && (FILL_W'(k + 1) == need)) ||
                                    (accept && (fill_eff < need) && (FILL_W'(k) == fill_eff));

      srep_win_cell u_cell (
         .clock     (clock),
         .ctrl      (win_ctrl[k]),
         .nbr_byte  (nbr),
         .new_byte  (req_tdata),
         .pat_byte  (pattern_ff[8*k +: 8]),
         .held_byte (win_byte[k]),
         .hit       (win_hit[k])
      );
   end

   // match or end of stream empties the window
   always_comb begin
      fill_in = fill_eff;
      if (accept) begin
         if (match || req_tlast) begin
            fill_in = '0;
         end else if (fill_eff < need) begin
            fill_in = fill_eff + FILL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else if (csr_we && (srep_pkg::csr_index_type'(csr_addr) ==
                              srep_pkg::REG_PATTERN_LENGTH)) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // ---------------- burst builder ----------------
   for (genvar j = 0; j < DEPTH; j++) begin : g_pad
      if (j < WIN_DEPTH) begin : g_have
         assign win_pad[j] = win_byte[j];
      end else begin : g_none
         assign win_pad[j] = 8'h00;
      end
   end

   // match: replacement; eos: held bytes then new byte; else one word if full
   always_comb begin
      if (match) begin
         burst_cnt = rlen_eff;
      end else if (req_tlast) begin
         burst_cnt = fill_cnt + CNT_W'(1);
      end else if (win_full) begin
         burst_cnt = CNT_W'(1);
      end else begin
         burst_cnt = '0;
      end
      for (int j = 0; j < DEPTH; j++) begin
         load_slot[j].valid = (CNT_W'(j) < burst_cnt);
         load_slot[j].last  = (CNT_W'(j + 1) == burst_cnt);
         if (match) begin
            load_slot[j].data = replace_ff[8*j +: 8];
         end else if (CNT_W'(j) < fill_cnt) begin
            load_slot[j].data = win_pad[j];
         end else begin
            load_slot[j].data = req_tdata;
         end
      end
   end

   // ---------------- result slot chain ----------------
   for (genvar j = 0; j < DEPTH; j++) begin : g_out
      if (j + 1 < DEPTH) begin : g_mid
         assign next_slot[j] = slot[j+1];
      end else begin : g_end
         assign next_slot[j] = '0;
      end

      srep_out_cell u_slot (
         .clock     (clock),
         .reset     (reset),
         .load      (accept),
         .advance   (advance),
         .load_slot (load_slot[j]),
         .next_slot (next_slot[j]),
         .slot      (slot[j])
      );
   end

   // take a new word when the chain is empty or its final word leaves now
   assign req_tready = !slot[0].valid || (rsp_tready && !slot[1].valid);

   assign rsp_tvalid = slot[0].valid;
   assign rsp_tdata  = slot[0].data;
   assign rsp_tlast  = slot[0].last;

endmodule

FILE: tb/sv/tb_stream_string_replace_unit.sv
// testbench for stream_string_replace_unit: directed table then random byte streams,
// every result word checked against a built-in search/replace predictor or, for
// typed rows, against the typed byte; depends on srep_pkg and the unit's rtl only
`timescale 1ns / 100ps

module tb_stream_string_replace_unit;

   localparam int N_RANDOM    = 340;
   localparam int CYCLE_LIMIT = 300000;
   localparam int N_DIRECTED  = 36;
   localparam int HOLD_CYCLES = 120;

   typedef enum logic {ROW_WORD, ROW_CFG} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      srep_pkg::csr_index_type addr;
      logic [63:0]             value;
      logic [7:0]              data;
      logic                    eos;
      logic                    typed;
      logic [3:0]              n_typed;
      logic [7:0]              typed_byte;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } out_word_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   // req_tdata: [7:0] data_byte
   logic [7:0]        req_tdata = 8'h00;
   logic              req_tlast = 1'b0;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   // rsp_tdata: [7:0] out_byte
   logic [7:0]        rsp_tdata;
   logic              rsp_tlast;
   logic              rsp_tvalid;
   logic              rsp_tready = 1'b0;
   logic              csr_we = 1'b0;
   logic [1:0]        csr_addr = 2'd0;
   logic [srep_pkg::REG_W-1:0] csr_wdata = '0;

   // predictor state
   logic [63:0] pat_bytes_m = 64'h0;
   logic [3:0]  pat_len_m = 4'd1;
   logic [63:0] rep_bytes_m = 64'h0;
   logic [3:0]  rep_len_m = 4'd0;
   logic [7:0]  win_q [8];
   int          win_fill = 0;

   out_word_type expected_words [$];
   int          mismatch_count = 0;
   int          words_sent = 0;
   int          burst_left = 0;
   int          hold_requests = 0;
   int          holds_granted = 0;
   int          cycle_count = 0;

   stim_row_type directed_rows [N_DIRECTED] = '{
      // after reset: pattern is one zero byte, replacement empty
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h41, 1'b0, 1'b1, 4'd1, 8'h41},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h00, 1'b0, 1'b1, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'hff, 1'b1, 1'b1, 4'd1, 8'hff},
      // length zero acts as one, replace length above eight saturates
      '{ROW_CFG,  srep_pkg::REG_PATTERN_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_CFG,  srep_pkg::REG_PATTERN_BYTES,  64'hff, 8'h00, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_CFG,  srep_pkg::REG_REPLACE_BYTES,  64'h0123456789abcdef,
        8'h00, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_CFG,  srep_pkg::REG_REPLACE_LENGTH, 64'hf, 8'h00, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'hff, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h00, 1'b1, 1'b0, 4'd0, 8'h00},
      // pattern length above eight saturates
      '{ROW_CFG,  srep_pkg::REG_PATTERN_LENGTH, 64'hf, 8'h00, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_CFG,  srep_pkg::REG_PATTERN_BYTES,  64'hffffffffffffffff,
        8'h00, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_CFG,  srep_pkg::REG_REPLACE_LENGTH, 64'h8, 8'h00, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'hff, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'hff, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'hff, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'hff, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'hff, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'hff, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'hff, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'hff, 1'b0, 1'b0, 4'd0, 8'h00},
      // partial window flushed by end of stream
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h12, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h34, 1'b1, 1'b0, 4'd0, 8'h00},
      // held bytes dropped by a length write
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h61, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h62, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_CFG,  srep_pkg::REG_PATTERN_LENGTH, 64'h3, 8'h00, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_CFG,  srep_pkg::REG_PATTERN_BYTES,  64'h636261, 8'h00, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_CFG,  srep_pkg::REG_REPLACE_LENGTH, 64'h0, 8'h00, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h61, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h62, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h63, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h61, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h62, 1'b1, 1'b0, 4'd0, 8'h00},
      // pattern bytes changed while the window holds a byte
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h61, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_CFG,  srep_pkg::REG_PATTERN_BYTES,  64'h646261, 8'h00, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h62, 1'b0, 1'b0, 4'd0, 8'h00},
      '{ROW_WORD, srep_pkg::REG_PATTERN_BYTES,  64'h0, 8'h64, 1'b0, 1'b0, 4'd0, 8'h00}
   };

   stream_string_replace_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int pattern_len_eff();
      int p;
      p = pat_len_m;
      if (p < 1) p = 1;
      if (p > 8) p = 8;
      return p;
   endfunction

   // advances the predictor by one input byte and returns the bytes it emits
   function automatic int predict_replace(input logic [7:0] b, input logic eos,
                                          output logic [7:0] outs [8]);
      int need, n, k, rl;
      bit hit;
      need = pattern_len_eff() - 1;
      n = 0;
      for (k = 0; k < 8; k++) outs[k] = 8'h00;
      if (win_fill > need) win_fill = need;
      if (win_fill == need) begin
         hit = (pat_bytes_m[8*need +: 8] == b);
         for (k = 0; k < need; k++)
            if (win_q[k] != pat_bytes_m[8*k +: 8]) hit = 1'b0;
         if (hit) begin
            rl = (rep_len_m > 8) ? 8 : int'(rep_len_m);
            for (k = 0; k < rl; k++) begin
               outs[n] = rep_bytes_m[8*k +: 8];
               n++;
            end
            win_fill = 0;
         end else if (need == 0) begin
            outs[n] = b;
            n++;
         end else begin
            outs[n] = win_q[0];
            n++;
            for (k = 1; k < need; k++) win_q[k-1] = win_q[k];
            win_q[need-1] = b;
         end
      end else begin
         win_q[win_fill] = b;
         win_fill++;
      end
      if (eos) begin
         for (k = 0; k < win_fill; k++) begin
            if (n < 8) begin
               outs[n] = win_q[k];
               n++;
            end
         end
         win_fill = 0;
      end
      return n;
   endfunction

   // offers one word, waits for it to be taken and queues what it should produce
   task automatic send_word(input logic [7:0] b, input logic eos, input logic typed,
                            input int n_typed, input logic [7:0] typed_byte);
      logic [7:0] outs [8];
      int n, k, gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 5);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= eos;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      words_sent++;
      n = predict_replace(b, eos, outs);
      if (typed) begin
         if (n_typed != 0) expected_words.push_back('{typed_byte, 1'b1});
      end else begin
         for (k = 0; k < n; k++) expected_words.push_back('{outs[k], k == n - 1});
      end
   endtask

   // leaves csr_we high; the caller lowers it after the last write of a group
   task automatic write_reg(input srep_pkg::csr_index_type addr, input logic [63:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= addr;
      csr_wdata <= value;
      @(posedge clock);
      case (addr)
         srep_pkg::REG_PATTERN_BYTES: pat_bytes_m = value;
         srep_pkg::REG_PATTERN_LENGTH: begin
            pat_len_m = value[3:0];
            win_fill = 0;
         end
         srep_pkg::REG_REPLACE_BYTES: rep_bytes_m = value;
         srep_pkg::REG_REPLACE_LENGTH: rep_len_m = value[3:0];
         default: ;
      endcase
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   always @(posedge clock) begin : rsp_check
      out_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected word: data %02h last %0b", rsp_tdata, rsp_tlast);
         end else begin
            want = expected_words.pop_front();
            if (rsp_tdata !== want.data || rsp_tlast !== want.last) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("mismatch: expected data %02h last %0b, got data %02h last %0b",
                           want.data, want.last, rsp_tdata, rsp_tlast);
            end
         end
      end
   end

   // receiver pacing: runs of random stall density, plus long hold-offs on request
   initial begin : rsp_pacing
      int run_left, stall_pct, hold_left;
      run_left = 0;
      stall_pct = 0;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (holds_granted != hold_requests) begin
            holds_granted++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            if (run_left == 0) begin
               run_left = $urandom_range(5, 40);
               case ($urandom_range(0, 2))
                  0: stall_pct = 0;
                  1: stall_pct = 30;
                  default: stall_pct = 75;
               endcase
            end
            run_left--;
            rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
         end
      end
   end

   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("[stream_string_replace_unit] ERROR");
      $finish;
   end

   initial begin : stimulus
      stim_row_type r;
      logic [7:0]  stream_q [$];
      logic [63:0] v;
      int          i, k, phase, phase_len, plen, cut, pick;
      logic        eos;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < N_DIRECTED; i++) begin
         r = directed_rows[i];
         if (r.kind == ROW_CFG) begin
            if (i == 0 || directed_rows[i-1].kind != ROW_CFG) wait_idle();
            write_reg(r.addr, r.value);
            if (i == N_DIRECTED - 1 || directed_rows[i+1].kind != ROW_CFG) csr_we <= 1'b0;
         end else begin
            send_word(r.data, r.eos, r.typed, r.n_typed, r.typed_byte);
         end
      end

      phase = 0;
      while (words_sent < N_RANDOM + 25) begin
         wait_idle();
         if (phase == 0 || $urandom_range(0, 1) == 1) begin
            v = {$urandom, $urandom};
            // small alphabet most of the time so matches and near misses are common
            if ($urandom_range(0, 2) != 0)
               for (k = 0; k < 8; k++) v[8*k +: 8] = 8'h61 + 8'($urandom_range(0, 1));
            write_reg(srep_pkg::REG_PATTERN_BYTES, v);
         end
         if (phase == 0 || $urandom_range(0, 2) == 0) begin
            v = {$urandom, $urandom};
            case ($urandom_range(0, 9))
               0: v[3:0] = 4'd0;
               1: v[3:0] = 4'($urandom_range(9, 15));
               2: v[3:0] = 4'd8;
               default: v[3:0] = 4'($urandom_range(1, 5));
            endcase
            write_reg(srep_pkg::REG_PATTERN_LENGTH, v);
         end
         if (phase == 0 || $urandom_range(0, 2) == 0)
            write_reg(srep_pkg::REG_REPLACE_BYTES, {$urandom, $urandom});
         if (phase == 0 || $urandom_range(0, 2) == 0) begin
            v = {$urandom, $urandom};
            v[3:0] = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                                 : 4'($urandom_range(0, 8));
            write_reg(srep_pkg::REG_REPLACE_LENGTH, v);
         end
         csr_we <= 1'b0;

         phase_len = $urandom_range(8, 40);
         if (phase % 6 == 3) begin
            // receiver blocks while the sender keeps pushing with no gaps
            hold_requests++;
            burst_left = 80;
            phase_len = 60;
         end

         plen = pattern_len_eff();
         stream_q.delete();
         while (stream_q.size() < phase_len) begin
            pick = $urandom_range(0, 9);
            if (pick < 4) begin
               for (k = 0; k < plen; k++) stream_q.push_back(pat_bytes_m[8*k +: 8]);
            end else if (pick < 6) begin
               cut = $urandom_range(0, plen - 1);
               for (k = 0; k < cut; k++) stream_q.push_back(pat_bytes_m[8*k +: 8]);
               stream_q.push_back(8'h61 + 8'($urandom_range(0, 1)));
            end else if (pick < 8) begin
               stream_q.push_back(8'h61 + 8'($urandom_range(0, 1)));
            end else begin
               stream_q.push_back(8'($urandom));
            end
         end

         for (k = 0; k < stream_q.size(); k++) begin
            eos = ($urandom_range(0, 99) < 4);
            if (k == stream_q.size() - 1 && $urandom_range(0, 9) < 6) eos = 1'b1;
            send_word(stream_q[k], eos, 1'b0, 0, 8'h00);
         end
         phase++;
      end

      req_tvalid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && expected_words.size() == 0) begin
         $display("[stream_string_replace_unit] OK");
      end else begin
         $display("[stream_string_replace_unit] ERROR");
      end
      $finish;
   end

endmodule
